// ===== sv/mfqs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfqs_pkg
// Shared constants, request/result types and queue interface structs of the
// multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfqs_pkg;

  // Sizing
  localparam int LEVELS    = 4;
  localparam int MAX_TASKS = 16;
  localparam int CORES     = 2;
  localparam int QREGS     = 4;   // quantum registers in the config map

  localparam int TASK_W  = 4;     // task id field width
  localparam int CORE_W  = 1;     // core index field width
  localparam int CMD_W   = 3;
  localparam int QUANT_W = 16;
  localparam int NLVL_W  = 3;     // levels_in_use register width

  localparam int ACT_MAX = (LEVELS < QREGS) ? LEVELS : QREGS;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LCNT_W  = $clog2(ACT_MAX + 1);
  localparam int QIDX_W  = (QREGS > 1) ? $clog2(QREGS) : 1;
  localparam int PTR_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);

  // Register reset values
  localparam logic [NLVL_W-1:0] LEVELS_RST = NLVL_W'(4);
  localparam int                QUANT_RST0 = 4;

  // Config register indexes
  localparam logic [2:0] CFG_LEVELS = 3'd0;
  localparam logic [2:0] CFG_QUANT0 = 3'd1;
  localparam logic [2:0] CFG_QUANT3 = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_UNBLOCK = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_BLOCK   = 3'd3,
    CMD_EXIT    = 3'd4
  } cmd_e;

  typedef logic [TASK_W-1:0] task_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CORE_W-1:0] core_index;
    task_t             task_id;
  } req_t;

  typedef struct packed {
    task_t running_task;
    logic  core_idle;
  } res_t;

  // Per-level queue control and status
  typedef struct packed {
    logic  push;
    logic  pop;
    task_t data;
  } fifo_req_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    task_t head;
  } fifo_stat_t;

endpackage

// ===== sv/mfqs_level_fifo.sv =====
// ----------------------------------------------------------------------------
// mfqs_level_fifo
// Task id FIFO of one priority level, flop based, one push and one pop per
// cycle. A push onto a full queue is dropped; the push is judged before the
// pop of the same cycle.
// ----------------------------------------------------------------------------
module mfqs_level_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mfqs_pkg::fifo_req_t    req_i,
  output mfqs_pkg::fifo_stat_t   stat_o
);

  mfqs_pkg::task_t                store_q [mfqs_pkg::MAX_TASKS];
  logic [mfqs_pkg::PTR_W-1:0]     head_q, head_d;
  logic [mfqs_pkg::CNT_W-1:0]     count_q, count_d;
  logic [mfqs_pkg::PTR_W:0]       tail_sum;
  logic [mfqs_pkg::PTR_W-1:0]     tail;
  logic                           full;
  logic                           push_ok;

  assign full    = (count_q == mfqs_pkg::CNT_W'(mfqs_pkg::MAX_TASKS));
  assign push_ok = req_i.push && !full;

  // Tail address, wrapped at the queue depth
  assign tail_sum = (mfqs_pkg::PTR_W+1)'(head_q) + (mfqs_pkg::PTR_W+1)'(count_q);
  assign tail = (tail_sum >= (mfqs_pkg::PTR_W+1)'(mfqs_pkg::MAX_TASKS)) ?
                mfqs_pkg::PTR_W'(tail_sum - (mfqs_pkg::PTR_W+1)'(mfqs_pkg::MAX_TASKS)) :
                mfqs_pkg::PTR_W'(tail_sum);

  // Pointer update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (req_i.pop) begin
      if (head_q == mfqs_pkg::PTR_W'(mfqs_pkg::MAX_TASKS - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + mfqs_pkg::PTR_W'(1);
      end
    end
    count_d = count_q + mfqs_pkg::CNT_W'(push_ok) - mfqs_pkg::CNT_W'(req_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[tail] <= req_i.data;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = full;
  assign stat_o.head  = store_q[head_q];

endmodule

// ===== sv/multilevel_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Multilevel feedback queue scheduler for several cores: per-level task
// FIFOs, per-core current task, level and remaining quantum.
// ----------------------------------------------------------------------------
// A request is taken at every clock edge with start_i high; busy_o stays low,
// so one request per cycle is sustained. Each request is registered, worked
// off in the following cycle by a single pass over the queue heads and the
// addressed core's state, and tick, block and exit produce one result. The
// result is registered and appears on result_o with done_o high; it stays for
// exactly one cycle. The receiver cannot stall and must take it then. Load,
// unblock, unused commands and commands to a missing core give no result.
// Config writes take effect at the edge they are issued and belong in idle
// periods.
module multilevel_feedback_queue_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  mfqs_pkg::req_t                      req_i,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_index_i,
  input  logic [mfqs_pkg::QUANT_W-1:0]        cfg_data_i,
  output logic                                done_o,
  output mfqs_pkg::res_t                      result_o
);

  // Config registers
  logic [mfqs_pkg::NLVL_W-1:0]   levels_q;
  logic [mfqs_pkg::QUANT_W-1:0]  quant_q [mfqs_pkg::QREGS];

  // Input register
  logic                          req_vld_q;
  mfqs_pkg::req_t                req_q;

  // Result register
  logic                          done_q, done_d;
  mfqs_pkg::res_t                res_q, res_d;

  // Per-core state
  logic                          core_vld_q   [mfqs_pkg::CORES];
  mfqs_pkg::task_t               core_task_q  [mfqs_pkg::CORES];
  mfqs_pkg::lvl_t                core_level_q [mfqs_pkg::CORES];
  logic [mfqs_pkg::QUANT_W-1:0]  core_qleft_q [mfqs_pkg::CORES];

  // Remembered level per task
  mfqs_pkg::lvl_t                blocked_q [mfqs_pkg::MAX_TASKS];

  // Queues
  mfqs_pkg::fifo_req_t           fifo_req  [mfqs_pkg::LEVELS];
  mfqs_pkg::fifo_stat_t          fifo_stat [mfqs_pkg::LEVELS];

  // Decision signals
  logic [mfqs_pkg::LCNT_W-1:0]   n_act;
  logic                          core_ok;
  logic                          core_we;
  logic                          nxt_vld;
  mfqs_pkg::task_t               nxt_task;
  mfqs_pkg::lvl_t                nxt_level;
  logic [mfqs_pkg::QUANT_W-1:0]  nxt_qleft;
  logic                          blk_we;
  mfqs_pkg::task_t               blk_addr;
  mfqs_pkg::lvl_t                blk_data;

  assign busy_o = 1'b0;

  // Clamp a level to the lowest level in use
  function automatic mfqs_pkg::lvl_t clamp_lvl(mfqs_pkg::lvl_t lv,
                                               logic [mfqs_pkg::LCNT_W-1:0] n);
    mfqs_pkg::lvl_t r;
    r = lv;
    if (mfqs_pkg::LCNT_W'(lv) >= n) begin
      r = mfqs_pkg::LVL_W'(n - mfqs_pkg::LCNT_W'(1));
    end
    return r;
  endfunction

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= mfqs_pkg::LEVELS_RST;
      for (int i = 0; i < mfqs_pkg::QREGS; i++) begin
        quant_q[i] <= mfqs_pkg::QUANT_W'(mfqs_pkg::QUANT_RST0 << i);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        mfqs_pkg::CFG_LEVELS: begin
          levels_q <= mfqs_pkg::NLVL_W'(cfg_data_i);
        end
        [mfqs_pkg::CFG_QUANT0:mfqs_pkg::CFG_QUANT3]: begin
          quant_q[mfqs_pkg::QIDX_W'(cfg_index_i - mfqs_pkg::CFG_QUANT0)] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Effective number of levels: zero acts as one, capped at the level count
  always_comb begin
    if (levels_q == '0) begin
      n_act = mfqs_pkg::LCNT_W'(1);
    end else if (int'(levels_q) > mfqs_pkg::ACT_MAX) begin
      n_act = mfqs_pkg::LCNT_W'(mfqs_pkg::ACT_MAX);
    end else begin
      n_act = mfqs_pkg::LCNT_W'(levels_q);
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  assign core_ok = (int'(req_q.core_index) < mfqs_pkg::CORES);

  // Level queues
  for (genvar g = 0; g < mfqs_pkg::LEVELS; g++) begin : g_level
    mfqs_level_fifo u_fifo (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (fifo_req[g]),
      .stat_o (fifo_stat[g])
    );
  end

  // Scheduling decision for the registered request
  always_comb begin
    logic                          push_en;
    mfqs_pkg::lvl_t                push_lvl;
    mfqs_pkg::task_t               push_data;
    logic                          disp_en;
    logic                          found;
    mfqs_pkg::lvl_t                sel;
    mfqs_pkg::lvl_t                lv;
    logic                          avail [mfqs_pkg::LEVELS];
    mfqs_pkg::task_t               head_eff [mfqs_pkg::LEVELS];
    logic [mfqs_pkg::QIDX_W-1:0]   qidx;
    logic [mfqs_pkg::QUANT_W-1:0]  q;

    push_en   = 1'b0;
    push_lvl  = '0;
    push_data = req_q.task_id;
    disp_en   = 1'b0;
    found     = 1'b0;
    sel       = '0;
    lv        = clamp_lvl(core_level_q[req_q.core_index], n_act);
    core_we   = 1'b0;
    blk_we    = 1'b0;
    blk_addr  = req_q.task_id;
    blk_data  = '0;
    done_d    = 1'b0;
    nxt_vld   = core_vld_q[req_q.core_index];
    nxt_task  = core_task_q[req_q.core_index];
    nxt_level = core_level_q[req_q.core_index];
    nxt_qleft = core_qleft_q[req_q.core_index];

    if (req_vld_q) begin
      unique case (req_q.command)
        mfqs_pkg::CMD_LOAD: begin
          if (int'(req_q.task_id) < mfqs_pkg::MAX_TASKS) begin
            blk_we  = 1'b1;
            push_en = 1'b1;
          end
        end
        mfqs_pkg::CMD_UNBLOCK: begin
          if (int'(req_q.task_id) < mfqs_pkg::MAX_TASKS) begin
            push_en  = 1'b1;
            push_lvl = clamp_lvl(blocked_q[req_q.task_id], n_act);
          end
        end
        mfqs_pkg::CMD_TICK: begin
          if (core_ok) begin
            core_we = 1'b1;
            done_d  = 1'b1;
            if (core_qleft_q[req_q.core_index] != '0) begin
              nxt_qleft = core_qleft_q[req_q.core_index] - mfqs_pkg::QUANT_W'(1);
            end else begin
              // quantum used up: demote and requeue the running task
              if (core_vld_q[req_q.core_index]) begin
                if ((mfqs_pkg::LCNT_W'(lv) + mfqs_pkg::LCNT_W'(1)) < n_act) begin
                  lv = lv + mfqs_pkg::LVL_W'(1);
                end
                nxt_level = lv;
                push_en   = 1'b1;
                push_lvl  = lv;
                push_data = core_task_q[req_q.core_index];
              end
              disp_en = 1'b1;
            end
          end
        end
        mfqs_pkg::CMD_BLOCK: begin
          if (core_ok) begin
            core_we = 1'b1;
            done_d  = 1'b1;
            // promote and remember the level for the later unblock
            if (core_vld_q[req_q.core_index]) begin
              if (lv != '0) begin
                lv = lv - mfqs_pkg::LVL_W'(1);
              end
              nxt_level = lv;
              blk_addr  = core_task_q[req_q.core_index];
              blk_data  = lv;
              blk_we    = (int'(core_task_q[req_q.core_index]) < mfqs_pkg::MAX_TASKS);
            end
            disp_en = 1'b1;
          end
        end
        mfqs_pkg::CMD_EXIT: begin
          if (core_ok) begin
            core_we = 1'b1;
            done_d  = 1'b1;
            disp_en = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Queue heads as seen after this request's push
    for (int i = 0; i < mfqs_pkg::LEVELS; i++) begin
      avail[i]    = !fifo_stat[i].empty ||
                    (push_en && (push_lvl == mfqs_pkg::LVL_W'(i)));
      head_eff[i] = fifo_stat[i].empty ? push_data : fifo_stat[i].head;
    end

    // Highest non-empty level in use
    for (int i = 0; i < mfqs_pkg::LEVELS; i++) begin
      if (!found && (i < int'(n_act)) && avail[i]) begin
        found = 1'b1;
        sel   = mfqs_pkg::LVL_W'(i);
      end
    end

    qidx = (int'(sel) < mfqs_pkg::QREGS) ? mfqs_pkg::QIDX_W'(sel) :
                                           mfqs_pkg::QIDX_W'(mfqs_pkg::QREGS - 1);
    q    = quant_q[qidx];

    // Dispatch
    if (disp_en) begin
      if (found) begin
        nxt_vld   = 1'b1;
        nxt_task  = head_eff[sel];
        nxt_level = sel;
        nxt_qleft = (q == '0) ? '0 : q - mfqs_pkg::QUANT_W'(1);
      end else begin
        nxt_vld   = 1'b0;
        nxt_task  = '0;
        nxt_qleft = '0;
      end
    end

    for (int i = 0; i < mfqs_pkg::LEVELS; i++) begin
      fifo_req[i].push = push_en && (push_lvl == mfqs_pkg::LVL_W'(i));
      fifo_req[i].pop  = disp_en && found && (sel == mfqs_pkg::LVL_W'(i));
      fifo_req[i].data = push_data;
    end

    res_d.running_task = nxt_vld ? nxt_task : '0;
    res_d.core_idle    = !nxt_vld;
  end

  // Core state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mfqs_pkg::CORES; i++) begin
        core_vld_q[i]   <= 1'b0;
        core_task_q[i]  <= '0;
        core_level_q[i] <= '0;
        core_qleft_q[i] <= '0;
      end
    end else if (core_we) begin
      core_vld_q[req_q.core_index]   <= nxt_vld;
      core_task_q[req_q.core_index]  <= nxt_task;
      core_level_q[req_q.core_index] <= nxt_level;
      core_qleft_q[req_q.core_index] <= nxt_qleft;
    end
  end

  // Remembered levels, no reset
  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blocked_q[blk_addr] <= blk_data;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
